/* rtl/iir4_vector_sample_filter_defines.svh */
// Assertion macros used by the checker file.
`ifndef IIR4_VECTOR_SAMPLE_FILTER_DEFINES_SVH
`define IIR4_VECTOR_SAMPLE_FILTER_DEFINES_SVH

// Concurrent check on the rising clock edge, held off during reset.
`define IIR4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("iir4 check failed");

// Check that a condition in one cycle implies another in the next.
`define IIR4_ASSERT_NEXT(lbl, ante, cons) \
  `IIR4_ASSERT(lbl, (ante) |=> (cons))

`endif

/* rtl/iir4_pkg.sv */
package iir4_pkg;

  localparam int COEF_W         = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int NUM_AXES       = 3;
  localparam int TAPS           = 4;
  localparam int NUM_COEF       = 2 * TAPS + 1;
  localparam int TIME_W         = 64;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int STATUS_W       = 2;
  localparam int Q_DEPTH        = 2;
  localparam int Q_AW           = $clog2(Q_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0_B1 = 3'd0,
    CFG_B2_B3 = 3'd1,
    CFG_B4_A1 = 3'd2,
    CFG_A2_A3 = 3'd3,
    CFG_A4    = 3'd4
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FILTERED = 2'd0,
    ST_FIRST    = 2'd1,
    ST_BACKWARD = 2'd2
  } step_status_e;

  typedef enum logic [2:0] {
    BK_MUL = 3'b001,
    BK_SUM = 3'b010,
    BK_FIN = 3'b100
  } back_state_e;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

/* rtl/iir4_if.sv */
interface iir4_in_if #(
  parameter int SAMPLE_WIDTH = 20
);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_WIDTH-1:0]  sample_x;
  logic signed [SAMPLE_WIDTH-1:0]  sample_y;
  logic signed [SAMPLE_WIDTH-1:0]  sample_z;
  logic [iir4_pkg::TIME_W-1:0]     time_ns;

  modport source (output valid, sample_x, sample_y, sample_z, time_ns, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, time_ns, output ready);
endinterface

interface iir4_out_if #(
  parameter int SAMPLE_WIDTH = 20
);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_WIDTH-1:0]  out_x;
  logic signed [SAMPLE_WIDTH-1:0]  out_y;
  logic signed [SAMPLE_WIDTH-1:0]  out_z;
  logic [iir4_pkg::STATUS_W-1:0]   step_status;

  modport source (output valid, out_x, out_y, out_z, step_status, input ready);
  modport sink (input valid, out_x, out_y, out_z, step_status, output ready);
endinterface

/* rtl/iir4_front.sv */
module iir4_front #(
  parameter int SAMPLE_WIDTH = 20
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  iir4_in_if.sink sample_i,
  input  logic  q_full_i,
  output logic  push_o,
  output logic [iir4_pkg::NUM_AXES*SAMPLE_WIDTH+iir4_pkg::STATUS_W-1:0] push_data_o
);
  import iir4_pkg::*;

  logic              primed_q;
  logic [TIME_W-1:0] last_time_q;
  step_status_e      cls;

  assign sample_i.ready = !q_full_i;
  assign push_o         = sample_i.valid && !q_full_i;

  // Classify against the timestamp of the previous word; equal counts as forward.
  always_comb begin
    if (!primed_q) begin
      cls = ST_FIRST;
    end else if (sample_i.time_ns < last_time_q) begin
      cls = ST_BACKWARD;
    end else begin
      cls = ST_FILTERED;
    end
  end

  assign push_data_o = {cls, sample_i.sample_z, sample_i.sample_y, sample_i.sample_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      last_time_q <= '0;
    end else if (push_o) begin
      primed_q    <= 1'b1;
      last_time_q <= sample_i.time_ns;
    end
  end

endmodule

/* rtl/iir4_queue.sv */
module iir4_queue #(
  parameter int WIDTH = 62
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);
  import iir4_pkg::*;

  logic [WIDTH-1:0] slot_q [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]    count_q;

  assign full_o  = (count_q == (Q_AW+1)'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/iir4_back.sv */
module iir4_back #(
  parameter int SAMPLE_WIDTH = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iir4_pkg::cfg_wr_t cfg_i,
  input  logic              q_empty_i,
  input  logic [iir4_pkg::NUM_AXES*SAMPLE_WIDTH+iir4_pkg::STATUS_W-1:0] q_head_i,
  output logic              q_pop_o,
  iir4_out_if.source        result_o
);
  import iir4_pkg::*;

  localparam int PROD_W   = COEF_W + SAMPLE_WIDTH;
  localparam int ACC_W    = (PROD_W + 4 > 64) ? 64 : PROD_W + 4;
  localparam int STAT_LSB = NUM_AXES * SAMPLE_WIDTH;
  localparam logic signed [ACC_W-1:0] RND =
    {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // b0..b4 then a1..a4
  logic signed [COEF_W-1:0]       coef_q [NUM_COEF];
  logic signed [SAMPLE_WIDTH-1:0] head_x [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] cur_out [NUM_AXES];
  step_status_e                   head_status;
  back_state_e                    state_q, state_d;
  step_status_e                   status_q, status_d;
  logic                           out_valid_q, out_valid_d;
  logic                           slot_free, pass_commit, filt_commit;

  assign head_status = step_status_e'(q_head_i[STAT_LSB +: STATUS_W]);
  assign slot_free   = !out_valid_q || result_o.ready;

  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    pass_commit = 1'b0;
    filt_commit = 1'b0;
    case (state_q)
      BK_MUL: begin
        if (!q_empty_i) begin
          if (head_status == ST_FILTERED) begin
            q_pop_o = 1'b1;
            state_d = BK_SUM;
          end else if (slot_free) begin
            q_pop_o     = 1'b1;
            pass_commit = 1'b1;
          end
        end
      end
      BK_SUM: begin
        state_d = BK_FIN;
      end
      BK_FIN: begin
        // hold the finished sum until the output register frees up
        if (slot_free) begin
          filt_commit = 1'b1;
          state_d     = BK_MUL;
        end
      end
      default: begin
        state_d = BK_MUL;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !result_o.ready) || pass_commit || filt_commit;

  always_comb begin
    status_d = status_q;
    if (pass_commit) begin
      status_d = head_status;
    end else if (filt_commit) begin
      status_d = ST_FILTERED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_MUL;
      status_q    <= ST_FILTERED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_B0_B1: begin
          coef_q[0] <= cfg_i.data[COEF_W-1:0];
          coef_q[1] <= cfg_i.data[2*COEF_W-1:COEF_W];
        end
        CFG_B2_B3: begin
          coef_q[2] <= cfg_i.data[COEF_W-1:0];
          coef_q[3] <= cfg_i.data[2*COEF_W-1:COEF_W];
        end
        CFG_B4_A1: begin
          coef_q[4] <= cfg_i.data[COEF_W-1:0];
          coef_q[5] <= cfg_i.data[2*COEF_W-1:COEF_W];
        end
        CFG_A2_A3: begin
          coef_q[6] <= cfg_i.data[COEF_W-1:0];
          coef_q[7] <= cfg_i.data[2*COEF_W-1:COEF_W];
        end
        CFG_A4: begin
          coef_q[8] <= cfg_i.data[COEF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    logic signed [SAMPLE_WIDTH-1:0] inh_q [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] outh_q [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] cur_q;
    logic signed [SAMPLE_WIDTH-1:0] x_q;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic signed [PROD_W-1:0]       prod_d [NUM_COEF];
    logic signed [PROD_W-1:0]       prod_q [NUM_COEF];
    logic signed [ACC_W-1:0]        psum_d [3];
    logic signed [ACC_W-1:0]        psum_q [3];
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        shifted;
    logic [ACC_W-SAMPLE_WIDTH:0]    upper;

    assign head_x[a]  = q_head_i[a*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    assign cur_out[a] = cur_q;

    always_comb begin
      prod_d[0] = coef_q[0] * head_x[a];
      for (int k = 0; k < TAPS; k++) begin
        prod_d[k+1]      = coef_q[k+1] * inh_q[k];
        prod_d[TAPS+1+k] = coef_q[TAPS+1+k] * outh_q[k];
      end
    end

    // three partial sums; feedback terms enter negated
    always_comb begin
      psum_d[0] = ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2]);
      psum_d[1] = ACC_W'(prod_q[3]) + ACC_W'(prod_q[4]) - ACC_W'(prod_q[5]);
      psum_d[2] = ACC_W'(0) - ACC_W'(prod_q[6]) - ACC_W'(prod_q[7]) - ACC_W'(prod_q[8]);
    end

    // round half up, drop the fraction, clamp to the sample range
    always_comb begin
      acc     = psum_q[0] + psum_q[1] + psum_q[2] + RND;
      shifted = acc >>> COEF_FRAC_BITS;
      upper   = shifted[ACC_W-1:SAMPLE_WIDTH-1];
      if ((&upper) || !(|upper)) begin
        y = shifted[SAMPLE_WIDTH-1:0];
      end else if (shifted[ACC_W-1]) begin
        y = SAT_MIN;
      end else begin
        y = SAT_MAX;
      end
    end

    always_ff @(posedge clk_i) begin
      if (state_q == BK_MUL) begin
        prod_q <= prod_d;
        x_q    <= head_x[a];
      end
      if (state_q == BK_SUM) begin
        psum_q <= psum_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cur_q <= '0;
        for (int k = 0; k < TAPS; k++) begin
          inh_q[k]  <= '0;
          outh_q[k] <= '0;
        end
      end else if (pass_commit && head_status == ST_FIRST) begin
        cur_q <= head_x[a];
        for (int k = 0; k < TAPS; k++) begin
          outh_q[k] <= '0;
        end
      end else if (filt_commit) begin
        cur_q     <= y;
        inh_q[0]  <= x_q;
        outh_q[0] <= y;
        for (int k = 1; k < TAPS; k++) begin
          inh_q[k]  <= inh_q[k-1];
          outh_q[k] <= outh_q[k-1];
        end
      end
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.out_x       = cur_out[0];
  assign result_o.out_y       = cur_out[1];
  assign result_o.out_z       = cur_out[2];
  assign result_o.step_status = status_q;

endmodule

/* rtl/iir4_vector_sample_filter.sv */
// Three-axis fourth-order direct-form-I IIR filter with timestamp screening. The front
// takes one sample word per cycle while the queue has room, classifies it (first after
// reset, timestamp gone backwards, or to be filtered) and parks it in a two-word queue.
// For a filtered word the engine's BK_MUL state forms the nine products of Q4.28
// coefficients per axis, BK_SUM forms partial sums, and BK_FIN rounds, saturates and
// updates the histories once the output register is free. The next filtered word
// cannot start before that, as its feedback products use the output just produced.
// A first or backward word skips the filter steps. Results sit in an output register,
// so the front keeps taking words while a result waits, until the queue is full. Write
// the coefficients only while the block is idle; an index above four is ignored.
module iir4_vector_sample_filter #(
  parameter int SAMPLE_WIDTH = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  iir4_in_if.sink                            sample_i,
  iir4_out_if.source                         result_o,
  input  logic                               cfg_we_i,
  input  logic [iir4_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [iir4_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import iir4_pkg::*;

  localparam int Q_W = NUM_AXES * SAMPLE_WIDTH + STATUS_W;

  cfg_wr_t        cfg;
  logic           push, pop, q_full, q_empty;
  logic [Q_W-1:0] push_data, q_head;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  iir4_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  iir4_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  iir4_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (pop),
    .result_o  (result_o)
  );

endmodule

/* rtl/iir4_checker.sv */
`include "iir4_vector_sample_filter_defines.svh"

module iir4_checker #(
  parameter int SAMPLE_WIDTH = 20
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0]    in_x_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0]    out_x_i,
  input logic signed [SAMPLE_WIDTH-1:0]    out_y_i,
  input logic signed [SAMPLE_WIDTH-1:0]    out_z_i,
  input logic [iir4_pkg::STATUS_W-1:0]     out_status_i
);
  import iir4_pkg::*;

  logic                           in_seen_q, out_seen_q;
  logic signed [SAMPLE_WIDTH-1:0] first_x_q, prev_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seen_q  <= 1'b0;
      out_seen_q <= 1'b0;
      first_x_q  <= '0;
      prev_x_q   <= '0;
    end else begin
      if (in_valid_i && in_ready_i && !in_seen_q) begin
        in_seen_q <= 1'b1;
        first_x_q <= in_x_i;
      end
      if (out_valid_i && out_ready_i) begin
        out_seen_q <= 1'b1;
        prev_x_q   <= out_x_i;
      end
    end
  end

  `IIR4_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable({out_x_i, out_y_i, out_z_i, out_status_i}))
  `IIR4_ASSERT(a_first_leads, out_valid_i && !out_seen_q |-> out_status_i == ST_FIRST)
  `IIR4_ASSERT(a_first_once, out_valid_i && out_seen_q |-> out_status_i != ST_FIRST)
  `IIR4_ASSERT(a_first_echo, out_valid_i && out_status_i == ST_FIRST |-> out_x_i == first_x_q)
  `IIR4_ASSERT(a_back_repeat, out_valid_i && out_status_i == ST_BACKWARD |-> out_x_i == prev_x_q)

endmodule

bind iir4_vector_sample_filter iir4_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_iir4_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .in_x_i       (sample_i.sample_x),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_x_i      (result_o.out_x),
  .out_y_i      (result_o.out_y),
  .out_z_i      (result_o.out_z),
  .out_status_i (result_o.step_status)
);

/* verif/iir4_result_checker.sv */
`timescale 1ns / 100ps

module iir4_result_checker #(
  parameter int SAMPLE_WIDTH = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  iir4_in_if                             sample_mon,
  iir4_out_if                            result_mon,
  input  logic                           cfg_we_i,
  input  logic [iir4_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [iir4_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                             mismatches_o,
  output int                             outstanding_o
);
  import iir4_pkg::*;

  localparam longint SAT_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] out_x;
    logic signed [SAMPLE_WIDTH-1:0] out_y;
    logic signed [SAMPLE_WIDTH-1:0] out_z;
    step_status_e                   status;
  } filt_word_t;

  bit [CFG_W-1:0]  coef_reg [5];
  bit              started;
  bit [TIME_W-1:0] stamp_last;
  longint          x_hist [NUM_AXES][TAPS];
  longint          y_hist [NUM_AXES][TAPS];
  longint          held_out [NUM_AXES];
  filt_word_t      predicted_results [$];
  int              result_seq;

  // Coefficients in order b0..b4, a1..a4; two per register (a4 alone in the last), low half first.
  function automatic longint coef_at(int n);
    logic [COEF_W-1:0] half;
    half = n[0] ? coef_reg[n >> 1][63:32] : coef_reg[n >> 1][31:0];
    return longint'($signed(half));
  endfunction

  function automatic longint axis_filter_out(int ax, longint xin);
    longint acc;
    int     k;
    acc = coef_at(0) * xin;
    for (k = 0; k < TAPS; k++) begin
      acc += coef_at(k + 1) * x_hist[ax][k];
      acc -= coef_at(k + 5) * y_hist[ax][k];
    end
    acc = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (acc > SAT_MAX) acc = SAT_MAX;
    if (acc < SAT_MIN) acc = SAT_MIN;
    return acc;
  endfunction

  task automatic predict_sample(input logic signed [SAMPLE_WIDTH-1:0] sx,
                                input logic signed [SAMPLE_WIDTH-1:0] sy,
                                input logic signed [SAMPLE_WIDTH-1:0] sz,
                                input logic [TIME_W-1:0] t);
    filt_word_t w;
    longint     xin [NUM_AXES];
    longint     yv;
    int         ax, k;
    xin[0] = sx;
    xin[1] = sy;
    xin[2] = sz;
    if (!started) begin
      // pass the first word through; input history stays as it is
      for (ax = 0; ax < NUM_AXES; ax++) begin
        held_out[ax] = xin[ax];
        for (k = 0; k < TAPS; k++) y_hist[ax][k] = 0;
      end
      started = 1'b1;
      w.status = ST_FIRST;
    end else if (t < stamp_last) begin
      w.status = ST_BACKWARD;
    end else begin
      for (ax = 0; ax < NUM_AXES; ax++) begin
        yv = axis_filter_out(ax, xin[ax]);
        for (k = TAPS - 1; k > 0; k--) begin
          x_hist[ax][k] = x_hist[ax][k-1];
          y_hist[ax][k] = y_hist[ax][k-1];
        end
        x_hist[ax][0] = xin[ax];
        y_hist[ax][0] = yv;
        held_out[ax]  = yv;
      end
      w.status = ST_FILTERED;
    end
    stamp_last = t;
    w.out_x = held_out[0][SAMPLE_WIDTH-1:0];
    w.out_y = held_out[1][SAMPLE_WIDTH-1:0];
    w.out_z = held_out[2][SAMPLE_WIDTH-1:0];
    predicted_results.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: result word %0d: %s is %0d, predicted %0d",
             $time, result_seq, what, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    filt_word_t want;
    int         a, k;
    if (!rst_ni) begin
      for (a = 0; a < 5; a++) coef_reg[a] = '0;
      for (a = 0; a < NUM_AXES; a++) begin
        held_out[a] = 0;
        for (k = 0; k < TAPS; k++) begin
          x_hist[a][k] = 0;
          y_hist[a][k] = 0;
        end
      end
      started    = 1'b0;
      stamp_last = '0;
      predicted_results.delete();
      result_seq    = 0;
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_B0_B1: coef_reg[0] = cfg_wdata_i;
          CFG_B2_B3: coef_reg[1] = cfg_wdata_i;
          CFG_B4_A1: coef_reg[2] = cfg_wdata_i;
          CFG_A2_A3: coef_reg[3] = cfg_wdata_i;
          CFG_A4:    coef_reg[4] = {32'h0, cfg_wdata_i[31:0]};
          default: ;
        endcase
      end
      if (sample_mon.valid && sample_mon.ready)
        predict_sample(sample_mon.sample_x, sample_mon.sample_y, sample_mon.sample_z,
                       sample_mon.time_ns);
      if (result_mon.valid && result_mon.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected word, step_status", result_mon.step_status, -1);
        end else begin
          want = predicted_results.pop_front();
          if (result_mon.out_x !== want.out_x)
            report_mismatch("out_x", result_mon.out_x, want.out_x);
          if (result_mon.out_y !== want.out_y)
            report_mismatch("out_y", result_mon.out_y, want.out_y);
          if (result_mon.out_z !== want.out_z)
            report_mismatch("out_z", result_mon.out_z, want.out_z);
          if (result_mon.step_status !== want.status)
            report_mismatch("step_status", result_mon.step_status, want.status);
        end
        result_seq++;
      end
      outstanding_o = predicted_results.size();
    end
  end

endmodule

/* verif/tb_iir4_vector_sample_filter.sv */
`timescale 1ns / 100ps

module tb_iir4_vector_sample_filter;
  import iir4_pkg::*;

  localparam int SW          = 20;
  localparam int RUN_LIMIT   = 300000;
  localparam int PHASES      = 9;
  localparam int PHASE_WORDS = 160;
  localparam int TAIL_CYCLES = 20;

  localparam logic signed [SW-1:0]  S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]  S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [COEF_W-1:0]     Q_ONE = 32'h1000_0000;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_SPARE = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_W-1:0]      cfg_wdata;
  int                    mismatches;
  int                    outstanding;
  bit                    calm;
  logic [TIME_W-1:0]     stamp;

  iir4_in_if  #(.SAMPLE_WIDTH(SW)) sample_if ();
  iir4_out_if #(.SAMPLE_WIDTH(SW)) result_if ();

  iir4_vector_sample_filter #(
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  iir4_result_checker #(
    .SAMPLE_WIDTH(SW)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_mon    (sample_if),
    .result_mon    (result_if),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic signed [SW-1:0] rand_axis();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: return S_MAX;
      1: return S_MIN;
      2, 3: return SW'(int'($urandom_range(0, 2000)) - 1000);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] mild_coef();
    return COEF_W'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
  endfunction

  // Lower valid, then hold until every predicted word has come back.
  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic signed [SW-1:0] sx, input logic signed [SW-1:0] sy,
                             input logic signed [SW-1:0] sz, input logic [TIME_W-1:0] t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid    <= 1'b1;
    sample_if.sample_x <= sx;
    sample_if.sample_y <= sy;
    sample_if.sample_z <= sz;
    sample_if.time_ns  <= t;
    stamp = t;
    do @(posedge clk_i); while (!sample_if.ready);
  endtask

  task automatic write_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                             input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] b3,
                             input logic [COEF_W-1:0] b4, input logic [COEF_W-1:0] a1,
                             input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] a3,
                             input logic [COEF_W-1:0] a4, input bit spare);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_B0_B1;
    cfg_wdata <= {b1, b0};
    @(posedge clk_i);
    cfg_idx   <= CFG_B2_B3;
    cfg_wdata <= {b3, b2};
    @(posedge clk_i);
    cfg_idx   <= CFG_B4_A1;
    cfg_wdata <= {a1, b4};
    @(posedge clk_i);
    cfg_idx   <= CFG_A2_A3;
    cfg_wdata <= {a3, a2};
    @(posedge clk_i);
    // upper half of the a4 word is junk and must be dropped
    cfg_idx   <= CFG_A4;
    cfg_wdata <= {$urandom, a4};
    @(posedge clk_i);
    if (spare) begin
      cfg_idx   <= CFG_IDX_SPARE;
      cfg_wdata <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    result_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    result_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) begin
        stall = calm ? 0 : $urandom_range(0, 6);
        if (stall != 0) begin
          result_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          result_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("tb_iir4_vector_sample_filter: done, errors");
    $finish;
  end

  initial begin : stimulus
    int ph, n, pick;
    rst_ni             <= 1'b0;
    sample_if.valid    <= 1'b0;
    sample_if.sample_x <= '0;
    sample_if.sample_y <= '0;
    sample_if.sample_z <= '0;
    sample_if.time_ns  <= '0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_B0_B1;
    cfg_wdata          <= '0;
    calm  = 1'b0;
    stamp = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: write_coefs(Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        1: write_coefs('h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF,
                       'h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF, 1'b0);
        2: write_coefs('h8000_0000, 'h8000_0000, 'h8000_0000, 'h8000_0000, 'h8000_0000,
                       'h8000_0000, 'h8000_0000, 'h8000_0000, 'h8000_0000, 1'b0);
        3: write_coefs(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        4: write_coefs('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
        // gentle low-pass with a little feedback
        5: write_coefs('h0200_0000, 'h0200_0000, 'h0200_0000, 'h0200_0000, 'h0200_0000,
                       'hF800_0000, 'h0100_0000, 0, 0, 1'b0);
        6: write_coefs($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, 1'b1);
        7: write_coefs(mild_coef(), mild_coef(), mild_coef(), mild_coef(), mild_coef(),
                       mild_coef(), mild_coef(), mild_coef(), mild_coef(), 1'b0);
        default: write_coefs($urandom, $urandom, $urandom, $urandom, $urandom,
                             0, 0, 0, 0, 1'b0);
      endcase
      calm = (ph == 1) || ($urandom_range(0, 3) == 0);

      if (ph == 0) begin
        // identity filter: first word passes, then equal and backward stamps
        send_sample(S_MAX, S_MIN, 0, 64'd1000);
        send_sample(S_MIN, S_MAX, -1, 64'd1000);
        send_sample(1, -1, S_MAX, 64'd999);
        send_sample(S_MAX, S_MAX, S_MAX, 64'd999);
        send_sample(S_MIN, S_MIN, S_MIN, 64'd1001);
        send_sample(0, 0, 0, 64'd0);
        send_sample(20'sh55555, 20'shAAAAA, 20'sh0F0F0, 64'd0);
        send_sample(-1, 1, 0, '1);
        send_sample(S_MIN, S_MAX, 1, '1);
        send_sample(2, 3, 4, 64'hFFFF_FFFF_FFFF_FFFE);
        send_sample(5, 6, 7, 64'h8000_0000_0000_0000);
        send_sample(S_MAX, 0, S_MIN, 64'h8000_0000_0000_0001);
        send_sample(20'shAAAAA, 20'sh55555, 20'shF0F0F, 64'h5555_5555_5555_5555);
        send_sample(-2, -3, -4, 64'hAAAA_AAAA_AAAA_AAAA);
        send_sample(S_MAX, S_MAX, S_MIN, 64'hAAAA_AAAA_AAAA_AAAA);
        send_sample(100, -100, 0, 64'hAAAA_AAAA_AAAA_AAAB);
        send_sample(3, 2, 1, 64'd3);
        send_sample(1, 2, 3, 64'd2);
        send_sample(S_MIN, 0, S_MAX, 64'd2);
      end

      for (n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        // mostly forward stamps, with equal, backward and wild ones mixed in
        if (pick < 70)
          stamp = stamp + $urandom_range(1, 5000);
        else if (pick < 92 && pick >= 78 && stamp != 0)
          stamp = stamp - 1 - ({$urandom, $urandom} % stamp);
        else if (pick >= 92)
          stamp = {$urandom, $urandom};
        send_sample(rand_axis(), rand_axis(), rand_axis(), stamp);
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_iir4_vector_sample_filter: done, clean");
    else
      $display("tb_iir4_vector_sample_filter: done, errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/iir4_pkg.sv
rtl/iir4_if.sv
rtl/iir4_front.sv
rtl/iir4_queue.sv
rtl/iir4_back.sv
rtl/iir4_vector_sample_filter.sv
rtl/iir4_checker.sv
verif/iir4_result_checker.sv
verif/tb_iir4_vector_sample_filter.sv
